>>> src/bpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure compensation package
// Shared constants, register indexes, calibration and stage types, and the
// small arithmetic helpers used by the compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int unsigned OVERSAMPLING = 3;

	localparam logic [31:0] TEMP_REF    = 32'd4000;
	localparam logic [31:0] SENS_BIAS   = 32'd32768;
	localparam logic [31:0] PRESS_SCALE = 32'd50000;
	localparam logic [31:0] SCALE_OS    = PRESS_SCALE >> OVERSAMPLING;
	localparam logic [31:0] CORR_MI     = 32'd3791;
	localparam logic [31:0] CORR_MH     = 32'hFFFF_E343;
	localparam logic [31:0] CORR_MG     = 32'd3038;
	localparam logic [19:0] PRESS_MAX   = 20'hFFFFF;
	localparam logic [15:0] TEMP_MAX    = 16'h7FFF;
	localparam logic [15:0] TEMP_MIN    = 16'h8000;

	localparam int unsigned TDIV_W = 27;
	localparam int unsigned PDIV_W = 32;
	localparam int unsigned INDEX_W = 4;

	typedef enum logic [INDEX_W-1:0] {
		REG_AC1    = 4'd0,
		REG_AC2    = 4'd1,
		REG_AC3    = 4'd2,
		REG_AC4    = 4'd3,
		REG_AC5    = 4'd4,
		REG_AC6    = 4'd5,
		REG_B1_B2  = 4'd6,
		REG_MC_MD  = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [15:0] ac5;
		logic [15:0] ac6;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] mc;
		logic [15:0] md;
	} cal_t;

	typedef struct packed {
		logic [31:0] t;
		logic [31:0] b6;
		logic [23:0] up;
		logic        fault;
	} tp_t;

	typedef struct packed {
		logic [15:0] temperature;
		logic [19:0] pressure;
		logic        divide_fault;
	} res_t;

	function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
		return 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sx(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

>>> src/bpc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure compensation channels
// Valid/ready channels for raw readings in and compensated results out.
// ----------------------------------------------------------------------------
interface bpc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_temperature;
	logic [23:0] raw_pressure;

	modport source (output valid, raw_temperature, raw_pressure, input ready);
	modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temperature;
	logic        [19:0] pressure;
	logic               divide_fault;

	modport source (output valid, temperature, pressure, divide_fault, input ready);
	modport sink (input valid, temperature, pressure, divide_fault, output ready);
endinterface

>>> src/bpc_udiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with a sideband
// word and a valid bit that travel alongside.
// ----------------------------------------------------------------------------
module bpc_udiv #(
	parameter int unsigned NUM_W  = 32,
	parameter int unsigned DEN_W  = 32,
	parameter int unsigned SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	logic [NUM_W-1:0]  vld_q;
	logic [DEN_W-1:0]  rem_q  [NUM_W];
	logic [NUM_W-1:0]  num_q  [NUM_W];
	logic [NUM_W-1:0]  quo_q  [NUM_W];
	logic [DEN_W-1:0]  den_q  [NUM_W];
	logic [SIDE_W-1:0] side_q [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic              src_vld;
		logic [DEN_W-1:0]  src_rem;
		logic [NUM_W-1:0]  src_num;
		logic [NUM_W-1:0]  src_quo;
		logic [DEN_W-1:0]  src_den;
		logic [SIDE_W-1:0] src_side;
		logic [DEN_W:0]    trial;
		logic [DEN_W:0]    diff;

		if (k == 0) begin : g_first
			assign src_vld  = in_valid;
			assign src_rem  = '0;
			assign src_num  = num;
			assign src_quo  = '0;
			assign src_den  = den;
			assign src_side = side_in;
		end else begin : g_next
			assign src_vld  = vld_q[k-1];
			assign src_rem  = rem_q[k-1];
			assign src_num  = num_q[k-1];
			assign src_quo  = quo_q[k-1];
			assign src_den  = den_q[k-1];
			assign src_side = side_q[k-1];
		end

		assign trial = {src_rem, src_num[NUM_W-1]};
		assign diff  = trial - {1'b0, src_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
				num_q[k]  <= {src_num[NUM_W-2:0], 1'b0};
				quo_q[k]  <= {src_quo[NUM_W-2:0], ~diff[DEN_W]};
				den_q[k]  <= src_den;
				side_q[k] <= src_side;
			end
		end
	end

	assign out_valid = vld_q[NUM_W-1];
	assign quo       = quo_q[NUM_W-1];
	assign side_out  = side_q[NUM_W-1];

endmodule

>>> src/bpc_temp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature compensation stages
// Computes the temperature term b5, the true temperature and b6, with a
// pipelined signed division by the temperature divisor.
// ----------------------------------------------------------------------------
module bpc_temp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [15:0]   ut,
	input  logic [23:0]   up,
	input  bpc_pkg::cal_t cal,
	output logic          out_valid,
	output bpc_pkg::tp_t  out_data
);

	localparam int unsigned SIDE_W = 32 + 24 + 2;

	logic        vld_s1;
	logic [31:0] prod_s1;
	logic [23:0] up_s1;

	logic                         vld_s2;
	logic [31:0]                  x1_s2;
	logic [bpc_pkg::TDIV_W-1:0]   num_s2;
	logic [31:0]                  den_s2;
	logic                         neg_s2;
	logic                         fault_s2;
	logic [23:0]                  up_s2;

	logic                         div_vld;
	logic [bpc_pkg::TDIV_W-1:0]   div_quo;
	logic [SIDE_W-1:0]            div_side;

	logic        vld_s3;
	logic [31:0] b5_s3;
	logic [23:0] up_s3;
	logic        fault_s3;

	logic        vld_s4;
	bpc_pkg::tp_t data_s4;

	logic [31:0] diff_c;
	logic [31:0] x1_c;
	logic [31:0] den_c;
	logic [31:0] num_c;
	logic [31:0] qx_c;
	logic [31:0] b5_c;

	always_comb begin
		diff_c = {16'b0, ut} - {16'b0, cal.ac6};
		x1_c   = bpc_pkg::asr(prod_s1, 15);
		den_c  = x1_c + bpc_pkg::sx(cal.md);
		num_c  = {{5{cal.mc[15]}}, cal.mc, 11'b0};
		qx_c   = {{(32 - bpc_pkg::TDIV_W){1'b0}}, div_quo};
		b5_c   = div_side[25] ? (div_side[57:26] - qx_c) : (div_side[57:26] + qx_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= div_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= diff_c * {16'b0, cal.ac5};
			up_s1   <= up;

			x1_s2    <= x1_c;
			num_s2   <= num_c[31] ? bpc_pkg::TDIV_W'(-num_c) : num_c[bpc_pkg::TDIV_W-1:0];
			den_s2   <= den_c[31] ? -den_c : den_c;
			neg_s2   <= num_c[31] ^ den_c[31];
			fault_s2 <= (den_c == 32'd0);
			up_s2    <= up_s1;

			b5_s3    <= b5_c;
			up_s3    <= div_side[24:1];
			fault_s3 <= div_side[0];

			data_s4.t     <= bpc_pkg::asr(b5_s3 + 32'd8, 4);
			data_s4.b6    <= b5_s3 - bpc_pkg::TEMP_REF;
			data_s4.up    <= up_s3;
			data_s4.fault <= fault_s3;
		end
	end

	bpc_udiv #(
		.NUM_W  (bpc_pkg::TDIV_W),
		.DEN_W  (32),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.num       (num_s2),
		.den       (den_s2),
		.side_in   ({x1_s2, neg_s2, up_s2, fault_s2}),
		.out_valid (div_vld),
		.quo       (div_quo),
		.side_out  (div_side)
	);

	assign out_valid = vld_s4;
	assign out_data  = data_s4;

endmodule

>>> src/bpc_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure compensation stages
// Forms b3, b4 and b7, divides with the split branch, applies the final
// correction and saturates both results into the output register.
// ----------------------------------------------------------------------------
module bpc_press (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  bpc_pkg::tp_t  in_data,
	input  bpc_pkg::cal_t cal,
	output logic          out_valid,
	output bpc_pkg::res_t out_data
);

	localparam int unsigned SIDE_W = 32 + 2;

	logic [4:0]  vld_s;

	logic [31:0] sqp_s1, ac2b6_s1, ac3b6_s1, t_s1;
	logic [23:0] up_s1;
	logic        fault_s1;

	logic [31:0] sq_s2, x2a_s2, x1c_s2, t_s2;
	logic [23:0] up_s2;
	logic        fault_s2;

	logic [31:0] b2sq_s3, b1sq_s3, x2a_s3, x1c_s3, t_s3;
	logic [23:0] up_s3;
	logic        fault_s3;

	logic [31:0] b3_s4, xx_s4, t_s4;
	logic [23:0] up_s4;
	logic        fault_s4;

	logic [31:0] b4_s5, b7_s5, t_s5;
	logic        fault_s5;

	logic                       div_vld;
	logic [bpc_pkg::PDIV_W-1:0] div_quo;
	logic [SIDE_W-1:0]          div_side;

	logic        vld_s6, vld_s7, vld_s8, vld_s9;
	logic [31:0] p_s6, t_s6;
	logic        fault_s6;
	logic [31:0] m1_s7, m2_s7, p_s7, t_s7;
	logic        fault_s7;
	logic [31:0] m3_s8, x2_s8, p_s8, t_s8;
	logic        fault_s8;
	bpc_pkg::res_t res_s9;

	logic [31:0] x1_c, x3_c, b3_c, xx_c, a_c, pf_c;
	logic [15:0] tsat_c;
	logic [19:0] psat_c;

	always_comb begin
		x1_c = bpc_pkg::asr(b2sq_s3, 11);
		x3_c = x1_c + x2a_s3;
		b3_c = bpc_pkg::asr((((bpc_pkg::sx(cal.ac1) << 2) + x3_c) << bpc_pkg::OVERSAMPLING)
			+ 32'd2, 2);
		xx_c = bpc_pkg::asr(x1c_s3 + bpc_pkg::asr(b1sq_s3, 16) + 32'd2, 2);
		a_c  = bpc_pkg::asr(p_s6, 8);
		pf_c = p_s8 + bpc_pkg::asr(bpc_pkg::asr(m3_s8, 16) + x2_s8 + bpc_pkg::CORR_MI, 4);

		if ($signed(t_s8) > $signed(bpc_pkg::sx(bpc_pkg::TEMP_MAX))) begin
			tsat_c = bpc_pkg::TEMP_MAX;
		end else if ($signed(t_s8) < $signed(bpc_pkg::sx(bpc_pkg::TEMP_MIN))) begin
			tsat_c = bpc_pkg::TEMP_MIN;
		end else begin
			tsat_c = t_s8[15:0];
		end

		if (pf_c[31]) begin
			psat_c = '0;
		end else if (pf_c > {12'b0, bpc_pkg::PRESS_MAX}) begin
			psat_c = bpc_pkg::PRESS_MAX;
		end else begin
			psat_c = pf_c[19:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s  <= {vld_s[3:0], in_valid};
			vld_s6 <= div_vld;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqp_s1   <= in_data.b6 * in_data.b6;
			ac2b6_s1 <= bpc_pkg::sx(cal.ac2) * in_data.b6;
			ac3b6_s1 <= bpc_pkg::sx(cal.ac3) * in_data.b6;
			t_s1     <= in_data.t;
			up_s1    <= in_data.up;
			fault_s1 <= in_data.fault;

			sq_s2    <= bpc_pkg::asr(sqp_s1, 12);
			x2a_s2   <= bpc_pkg::asr(ac2b6_s1, 11);
			x1c_s2   <= bpc_pkg::asr(ac3b6_s1, 13);
			t_s2     <= t_s1;
			up_s2    <= up_s1;
			fault_s2 <= fault_s1;

			b2sq_s3  <= bpc_pkg::sx(cal.b2) * sq_s2;
			b1sq_s3  <= bpc_pkg::sx(cal.b1) * sq_s2;
			x2a_s3   <= x2a_s2;
			x1c_s3   <= x1c_s2;
			t_s3     <= t_s2;
			up_s3    <= up_s2;
			fault_s3 <= fault_s2;

			b3_s4    <= b3_c;
			xx_s4    <= xx_c;
			t_s4     <= t_s3;
			up_s4    <= up_s3;
			fault_s4 <= fault_s3;

			b4_s5    <= ({16'b0, cal.ac4} * (xx_s4 + bpc_pkg::SENS_BIAS)) >> 15;
			b7_s5    <= ({8'b0, up_s4} - b3_s4) * bpc_pkg::SCALE_OS;
			t_s5     <= t_s4;
			fault_s5 <= fault_s4;

			p_s6     <= div_side[33] ? {div_quo[30:0], 1'b0} : div_quo;
			t_s6     <= div_side[32:1];
			fault_s6 <= div_side[0];

			m1_s7    <= a_c * a_c;
			m2_s7    <= p_s6 * bpc_pkg::CORR_MH;
			p_s7     <= p_s6;
			t_s7     <= t_s6;
			fault_s7 <= fault_s6;

			m3_s8    <= m1_s7 * bpc_pkg::CORR_MG;
			x2_s8    <= bpc_pkg::asr(m2_s7, 16);
			p_s8     <= p_s7;
			t_s8     <= t_s7;
			fault_s8 <= fault_s7;

			res_s9.temperature  <= fault_s8 ? 16'd0 : tsat_c;
			res_s9.pressure     <= fault_s8 ? 20'd0 : psat_c;
			res_s9.divide_fault <= fault_s8;
		end
	end

	bpc_udiv #(
		.NUM_W  (bpc_pkg::PDIV_W),
		.DEN_W  (32),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s[4]),
		.num       (b7_s5[31] ? b7_s5 : {b7_s5[30:0], 1'b0}),
		.den       (b4_s5),
		.side_in   ({b7_s5[31], t_s5, fault_s5 | (b4_s5 == 32'd0)}),
		.out_valid (div_vld),
		.quo       (div_quo),
		.side_out  (div_side)
	);

	assign out_valid = vld_s9;
	assign out_data  = res_s9;

endmodule

>>> src/barometric_pressure_compensation_top.sv
`timescale 1ns / 1ps
// Throughput: one reading per cycle unless a result beat waits untaken; both dividers are
// pipelined one quotient bit per stage.
// The whole pipeline holds while a result beat waits and is not taken.
// Reset clears all valid bits and the calibration registers to zero.
// ----------------------------------------------------------------------------
// Barometric pressure compensation top level
// Calibration registers, temperature and pressure pipelines, output channel.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpc_pkg::INDEX_W-1:0]   cfg_index,
	input  logic [31:0]                   cfg_data,
	bpc_in_if.sink                        sample,
	bpc_out_if.source                     result
);

	bpc_pkg::cal_t cal_q;
	logic          en;
	logic          tp_valid;
	bpc_pkg::tp_t  tp_data;
	logic          res_valid;
	bpc_pkg::res_t res_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpc_pkg::REG_AC1: cal_q.ac1 <= cfg_data[15:0];
				bpc_pkg::REG_AC2: cal_q.ac2 <= cfg_data[15:0];
				bpc_pkg::REG_AC3: cal_q.ac3 <= cfg_data[15:0];
				bpc_pkg::REG_AC4: cal_q.ac4 <= cfg_data[15:0];
				bpc_pkg::REG_AC5: cal_q.ac5 <= cfg_data[15:0];
				bpc_pkg::REG_AC6: cal_q.ac6 <= cfg_data[15:0];
				bpc_pkg::REG_B1_B2: begin
					cal_q.b1 <= cfg_data[31:16];
					cal_q.b2 <= cfg_data[15:0];
				end
				bpc_pkg::REG_MC_MD: begin
					cal_q.mc <= cfg_data[31:16];
					cal_q.md <= cfg_data[15:0];
				end
				default: ;
			endcase
		end
	end

	assign en = !res_valid || result.ready;
	assign sample.ready = en;

	bpc_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sample.valid),
		.ut        (sample.raw_temperature),
		.up        (sample.raw_pressure),
		.cal       (cal_q),
		.out_valid (tp_valid),
		.out_data  (tp_data)
	);

	bpc_press u_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (tp_valid),
		.in_data   (tp_data),
		.cal       (cal_q),
		.out_valid (res_valid),
		.out_data  (res_data)
	);

	assign result.valid        = res_valid;
	assign result.temperature  = res_data.temperature;
	assign result.pressure     = res_data.pressure;
	assign result.divide_fault = res_data.divide_fault;

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.divide_fault |-> result.temperature == 16'sd0
			&& result.pressure == 20'd0)
		else $error("faulted beat carries nonzero results");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> sample.ready)
		else $error("input stalled with empty output");

	a_cal_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == bpc_pkg::REG_AC5 |=> cal_q.ac5 == $past(cfg_data[15:0]))
		else $error("calibration write lost");

endmodule
